// ===== rtl/core/dapu_pkg.sv =====
package dapu_pkg;

	localparam int WORKER_W = 3;
	localparam int INDEX_W  = 10;
	localparam int DATA_W   = 32;
	localparam int LR_W     = 24;
	localparam int HIST_W   = 64;
	localparam int ROOT_W   = HIST_W / 2;
	// rate * |gradient| / 256 stays below 2^47
	localparam int NUM_W    = LR_W + DATA_W - 9;
	localparam int RES_W    = NUM_W + 2;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [HIST_W-1:0] HIST_INIT = 64'h0000_0000_1999_999A;
	localparam logic [LR_W-1:0]   LR_RESET  = 24'd167772;

	// register index, taken from the word address
	localparam logic REG_LR = 1'b0;

	typedef struct packed {
		logic                     bypass;
		logic                     neg;
		logic signed [DATA_W-1:0] param;
		logic [NUM_W-1:0]         num;
	} dapu_sq_side_t;

	typedef struct packed {
		logic                     bypass;
		logic                     neg;
		logic signed [DATA_W-1:0] param;
	} dapu_div_side_t;

endpackage

// ===== rtl/core/dapu_ifs.sv =====
interface dapu_req_if import dapu_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [WORKER_W-1:0]        worker;
	logic [INDEX_W-1:0]         element_index;
	logic signed [DATA_W-1:0]   gradient;
	logic signed [DATA_W-1:0]   param_value;

	modport source (output valid, worker, element_index, gradient, param_value, input ready);
	modport sink (input valid, worker, element_index, gradient, param_value, output ready);
endinterface

interface dapu_rsp_if import dapu_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [DATA_W-1:0]   new_param;

	modport source (output valid, new_param, input ready);
	modport sink (input valid, new_param, output ready);
endinterface

// ===== rtl/core/dapu_isqrt.sv =====
module dapu_isqrt import dapu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [HIST_W-1:0] in_rad,
	input  dapu_sq_side_t     in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output dapu_sq_side_t     out_side
);

	localparam int STEPS = ROOT_W;

	logic [STEPS:0]    vld_s;
	logic [HIST_W-1:0] rad_s  [STEPS+1];
	logic [HIST_W-1:0] root_s [STEPS+1];
	dapu_sq_side_t     side_s [STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s[0]  <= in_rad;
			root_s[0] <= '0;
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [HIST_W-1:0] BIT = HIST_W'(1) << (HIST_W - 2 - 2 * k);
		logic [HIST_W-1:0] trial;
		logic              take;

		assign trial = root_s[k] + BIT;
		assign take  = rad_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_s[k+1]  <= take ? rad_s[k] - trial : rad_s[k];
				root_s[k+1] <= take ? (root_s[k] >> 1) + BIT : root_s[k] >> 1;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign out_root  = root_s[STEPS][ROOT_W-1:0];
	assign out_side  = side_s[STEPS];

endmodule

// ===== rtl/core/dapu_div.sv =====
module dapu_div import dapu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [ROOT_W-1:0] in_den,
	input  dapu_div_side_t    in_side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  out_quo,
	output dapu_div_side_t    out_side
);

	logic [NUM_W:0]    vld_s;
	logic [ROOT_W-1:0] rem_s  [NUM_W+1];
	logic [NUM_W-1:0]  nq_s   [NUM_W+1];
	logic [ROOT_W-1:0] den_s  [NUM_W+1];
	dapu_div_side_t    side_s [NUM_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]  <= '0;
			nq_s[0]   <= in_num;
			den_s[0]  <= in_den;
			side_s[0] <= in_side;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < NUM_W; k++) begin : g_step
		logic [ROOT_W:0] trial;
		logic [ROOT_W:0] diff;
		logic            ge;

		assign trial = {rem_s[k], nq_s[k][NUM_W-1]};
		assign diff  = trial - {1'b0, den_s[k]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1]  <= ge ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
				nq_s[k+1]   <= {nq_s[k][NUM_W-2:0], ge};
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[NUM_W];
	assign out_quo   = nq_s[NUM_W];
	assign out_side  = side_s[NUM_W];

endmodule

// ===== rtl/core/delayed_adagrad_param_update.sv =====
// Adagrad update for asynchronous workers, fully pipelined: one item is taken every clock
// cycle while the result is not stalled, and after the history update it passes the 32-stage
// square root and the 47-stage divider. A stalled result holds the whole pipeline until
// taken. After reset the history and per-worker snapshot memories are swept to their
// initial value, one entry a cycle, covering all 2^(clog2(WORKERS)+clog2(PARAM_COUNT))
// snapshot entries (8192 at the defaults), and no item is taken during that sweep. A repeated
// element in consecutive items is forwarded from the write stage, so any index pattern runs
// at full rate.
module delayed_adagrad_param_update import dapu_pkg::*; #(
	parameter int PARAM_COUNT = 1024,
	parameter int WORKERS     = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	dapu_req_if.sink            grad,
	dapu_rsp_if.source          result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	localparam int AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
	localparam int WW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
	localparam int SW = WW + AW;

	logic [LR_W-1:0]   lr_q;
	logic              clr_busy_q;
	logic [SW-1:0]     clr_q;
	logic              adv;
	logic              out_valid_q;
	logic [DATA_W-1:0] new_param_q;

	logic [HIST_W-1:0] hist_mem [2**AW];
	logic [HIST_W-1:0] snap_mem [2**SW];

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1] == REG_LR) ? PDATA_W'(lr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= LR_RESET;
		end else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_LR) begin
			lr_q <= pwdata[LR_W-1:0];
		end
	end

	// initial memory sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (&clr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign adv        = !out_valid_q || result.ready;
	assign grad.ready = adv && !clr_busy_q;

	// stage 1: capture item
	logic              vld_s1;
	logic              inr_s1;
	logic              neg_s1;
	logic [DATA_W-1:0] mag_s1;
	logic [DATA_W-1:0] param_s1;
	logic [AW-1:0]     hidx_s1;
	logic [SW-1:0]     sidx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= grad.valid && !clr_busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inr_s1   <= (int'(grad.worker) < WORKERS) && (int'(grad.element_index) < PARAM_COUNT);
			neg_s1   <= grad.gradient[DATA_W-1];
			mag_s1   <= grad.gradient[DATA_W-1] ? DATA_W'(-grad.gradient) : grad.gradient;
			param_s1 <= grad.param_value;
			hidx_s1  <= AW'(grad.element_index);
			sidx_s1  <= {WW'(grad.worker), AW'(grad.element_index)};
		end
	end

	// stage 2: memory read, products, history update
	logic                   vld_s2;
	logic                   inr_s2;
	logic                   neg_s2;
	logic [DATA_W-1:0]      param_s2;
	logic [AW-1:0]          hidx_s2;
	logic [SW-1:0]          sidx_s2;
	logic [HIST_W-1:0]      hist_rd_s2;
	logic [HIST_W-1:0]      snap_rd_s2;
	logic [HIST_W-1:0]      g2_s2;
	logic [LR_W+DATA_W-1:0] num_s2;
	logic                   fwd_h_s2;
	logic                   fwd_s_s2;
	logic [HIST_W-1:0]      fwd_val_s2;
	logic [HIST_W-1:0]      h_cur;
	logic [HIST_W-1:0]      sn_cur;
	logic [HIST_W:0]        h_sum;
	logic [HIST_W-1:0]      h_new;
	logic                   wr_en;

	assign h_cur  = fwd_h_s2 ? fwd_val_s2 : hist_rd_s2;
	assign sn_cur = fwd_s_s2 ? fwd_val_s2 : snap_rd_s2;
	assign h_sum  = {1'b0, h_cur} + {1'b0, g2_s2};
	assign h_new  = h_sum[HIST_W] ? '1 : h_sum[HIST_W-1:0];
	assign wr_en  = vld_s2 && inr_s2 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inr_s2     <= inr_s1;
			neg_s2     <= neg_s1;
			param_s2   <= param_s1;
			hidx_s2    <= hidx_s1;
			sidx_s2    <= sidx_s1;
			g2_s2      <= mag_s1 * mag_s1;
			num_s2     <= lr_q * mag_s1;
			fwd_h_s2   <= wr_en && hidx_s2 == hidx_s1;
			fwd_s_s2   <= wr_en && sidx_s2 == sidx_s1;
			fwd_val_s2 <= h_new;
			hist_rd_s2 <= hist_mem[hidx_s1];
			snap_rd_s2 <= snap_mem[sidx_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			hist_mem[clr_q[AW-1:0]] <= HIST_INIT;
			snap_mem[clr_q]         <= HIST_INIT;
		end else if (wr_en) begin
			hist_mem[hidx_s2] <= h_new;
			snap_mem[sidx_s2] <= h_new;
		end
	end

	// stage 3: growth since snapshot
	logic              vld_s3;
	logic              inr_s3;
	logic              neg_s3;
	logic [DATA_W-1:0] param_s3;
	logic [HIST_W-1:0] h_s3;
	logic [HIST_W-1:0] snap_s3;
	logic [NUM_W-1:0]  num_s3;
	logic [HIST_W:0]   dif;
	logic              zero;
	dapu_sq_side_t     sq_in_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inr_s3   <= inr_s2;
			neg_s3   <= neg_s2;
			param_s3 <= param_s2;
			h_s3     <= h_new;
			snap_s3  <= sn_cur;
			num_s3   <= num_s2[NUM_W+7:8];
		end
	end

	assign dif  = {1'b0, h_s3} - {1'b0, snap_s3};
	assign zero = dif[HIST_W] || (h_s3 == snap_s3);

	assign sq_in_side.bypass = !inr_s3 || zero;
	assign sq_in_side.neg    = neg_s3;
	assign sq_in_side.param  = param_s3;
	assign sq_in_side.num    = num_s3;

	logic              sq_valid;
	logic [ROOT_W-1:0] sq_root;
	dapu_sq_side_t     sq_side;
	dapu_div_side_t    dv_in_side;

	dapu_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (vld_s3),
		.in_rad    (dif[HIST_W-1:0]),
		.in_side   (sq_in_side),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	assign dv_in_side.bypass = sq_side.bypass;
	assign dv_in_side.neg    = sq_side.neg;
	assign dv_in_side.param  = sq_side.param;

	logic           dv_valid;
	logic [NUM_W-1:0] dv_quo;
	dapu_div_side_t dv_side;

	dapu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (sq_valid),
		.in_num    (sq_side.num),
		.in_den    (sq_root),
		.in_side   (dv_in_side),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_side  (dv_side)
	);

	// apply step and saturate
	logic signed [RES_W-1:0] p_ext;
	logic signed [RES_W-1:0] q_ext;
	logic signed [RES_W-1:0] sum;
	logic [DATA_W-1:0]       res;

	assign p_ext = RES_W'(dv_side.param);
	assign q_ext = signed'(RES_W'(dv_quo));
	assign sum   = dv_side.neg ? p_ext + q_ext : p_ext - q_ext;

	always_comb begin
		if (dv_side.bypass) begin
			res = dv_side.param;
		end else if (sum[RES_W-1:DATA_W-1] != '0 && sum[RES_W-1:DATA_W-1] != '1) begin
			res = sum[RES_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			res = sum[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			new_param_q <= res;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.new_param = new_param_q;

endmodule

// ===== rtl/core/dapu_checker.sv =====
module dapu_checker import dapu_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [DATA_W-1:0]  new_param,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	input logic [PDATA_W-1:0] prdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_param))
		else $error("result item changed while stalled");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item taken while pipeline stalled");

	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[PADDR_W-1] == REG_LR |=>
		paddr[PADDR_W-1] != REG_LR || prdata[LR_W-1:0] == $past(pwdata[LR_W-1:0]))
		else $error("rate register readback mismatch");

	a_sweep_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid && !in_ready)
		else $error("activity during memory sweep");

endmodule

bind delayed_adagrad_param_update dapu_checker u_dapu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (grad.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.new_param (result.new_param),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);

// ===== sim/delayed_adagrad_param_update_test.sv =====
module delayed_adagrad_param_update_test;
	import dapu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ELEM      = 1024;
	localparam int N_WORKER    = 8;
	localparam int LATENCY     = 85;
	localparam int IDLE_LIMIT  = 30000;
	localparam int LONG_HOLD   = 400;

	typedef struct packed {
		logic [WORKER_W-1:0]      worker;
		logic [INDEX_W-1:0]       element_index;
		logic signed [DATA_W-1:0] gradient;
		logic signed [DATA_W-1:0] param_value;
	} grad_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;
	logic pready;

	dapu_req_if grad_if ();
	dapu_rsp_if rsp_if ();

	delayed_adagrad_param_update dut (
		.clk(clk), .arst_n(arst_n), .grad(grad_if.sink), .result(rsp_if.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	grad_item_t pending_items[$];
	logic signed [DATA_W-1:0] expected_params[$];
	logic [HIST_W-1:0] history [N_ELEM];
	logic [HIST_W-1:0] snapshot [N_WORKER][N_ELEM];
	logic [LR_W-1:0] rate;
	int errors = 0;
	int items_in = 0, items_out = 0, zero_steps = 0, clamps = 0;
	int send_gap = 0, recv_gap = 0, idle_cycles = 0;
	bit gaps_on = 1'b1, held = 1'b0;

	function automatic logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [DATA_W-1:0] adagrad_step(grad_item_t it);
		longint g, p, r, st;
		logic [63:0] mag, g2, h, snap, delta, q;
		g = it.gradient;
		p = it.param_value;
		r = p;
		mag = (g < 0) ? -g : g;
		g2 = mag * mag;
		h = history[it.element_index];
		snap = snapshot[it.worker][it.element_index];
		h = (h > 64'hFFFF_FFFF_FFFF_FFFF - g2) ? 64'hFFFF_FFFF_FFFF_FFFF : h + g2;
		history[it.element_index] = h;
		delta = (h > snap) ? h - snap : 0;
		if (delta != 0) begin
			q = (64'(rate) * mag) / (root_floor(delta) * 256);
			st = (g < 0) ? -longint'(q) : longint'(q);
			r = p - st;
			if (r > 64'sd2147483647) begin
				r = 64'sd2147483647;
				clamps++;
			end
			if (r < -64'sd2147483648) begin
				r = -64'sd2147483648;
				clamps++;
			end
		end else begin
			zero_steps++;
		end
		snapshot[it.worker][it.element_index] = h;
		return r[DATA_W-1:0];
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 19);
		if (!gaps_on || k < 12)
			return 0;
		if (k < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			grad_if.valid <= 1'b0;
		end else if (!grad_if.valid || grad_if.ready) begin
			if (send_gap > 0) begin
				grad_if.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_items.size() > 0) begin
				grad_item_t it;
				it = pending_items.pop_front();
				grad_if.worker <= it.worker;
				grad_if.element_index <= it.element_index;
				grad_if.gradient <= it.gradient;
				grad_if.param_value <= it.param_value;
				grad_if.valid <= 1'b1;
				send_gap <= pick_gap();
			end else begin
				grad_if.valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off to back the pipeline up
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (!held && items_out >= 200) begin
			held <= 1'b1;
			recv_gap <= LONG_HOLD;
			rsp_if.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			rsp_if.ready <= 1'b0;
		end else if (rsp_if.ready && rsp_if.valid) begin
			recv_gap <= pick_gap();
			rsp_if.ready <= 1'b1;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (grad_if.valid && grad_if.ready) begin
				grad_item_t it;
				it.worker = grad_if.worker;
				it.element_index = grad_if.element_index;
				it.gradient = grad_if.gradient;
				it.param_value = grad_if.param_value;
				expected_params.push_back(adagrad_step(it));
				items_in++;
			end
			if (rsp_if.valid && rsp_if.ready) begin
				items_out++;
				if (expected_params.size() == 0)
					report_mismatch("unexpected item new_param", rsp_if.new_param, 0);
				else begin
					logic signed [DATA_W-1:0] want;
					want = expected_params.pop_front();
					if (rsp_if.new_param !== want)
						report_mismatch("new_param", rsp_if.new_param, want);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((grad_if.valid && grad_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout with %0d items outstanding", expected_params.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_rate(logic [LR_W-1:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({REG_LR, 2'b00});
		pwdata <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		rate = v;
	endtask

	task automatic add_item(int w, int idx, logic [31:0] g, logic [31:0] p);
		grad_item_t it;
		it.worker = WORKER_W'(w);
		it.element_index = INDEX_W'(idx);
		it.gradient = g;
		it.param_value = p;
		pending_items.push_back(it);
	endtask

	task automatic drain();
		wait (pending_items.size() == 0 && !grad_if.valid && expected_params.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_gradient();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 2000)) - 1000);
			default: return 32'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
		endcase
	endfunction

	task automatic random_items(int n);
		for (int i = 0; i < n; i++) begin
			int idx;
			idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, N_ELEM - 1)
				: $urandom_range(0, 15);
			add_item($urandom_range(0, N_WORKER - 1), idx, rand_gradient(),
				($urandom_range(0, 7) == 0) ? {$urandom_range(0, 1) ? 32'h7FFF_FF00 : 32'h8000_0100}
				: $urandom());
		end
	endtask

	initial begin
		logic [LR_W-1:0] settings[4];
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		grad_if.valid = 1'b0;
		grad_if.worker = '0;
		grad_if.element_index = '0;
		grad_if.gradient = '0;
		grad_if.param_value = '0;
		rsp_if.ready = 1'b0;
		rate = LR_RESET;
		for (int i = 0; i < N_ELEM; i++) begin
			history[i] = HIST_INIT;
			for (int w = 0; w < N_WORKER; w++)
				snapshot[w][i] = HIST_INIT;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, zero gradient, history saturation, clamped output
		add_item(0, 0, 32'h0, 32'h7FFF_FFFF);
		add_item(0, 0, 32'h0001_0000, 32'h8000_0000);
		add_item(1, 0, 32'hFFFF_0000, 32'h0);
		add_item(0, 0, 32'h0, 32'h1234_5678);
		add_item(7, 1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_item(7, 1023, 32'h8000_0000, 32'h8000_0000);
		for (int i = 0; i < 5; i++)
			add_item(i, 5, 32'h8000_0000, 32'h0000_1000);
		add_item(0, 5, 32'h0000_0001, 32'h0);
		add_item(2, 6, 32'h0000_0001, 32'h7FFF_FFF0);
		add_item(3, 7, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		add_item(4, 8, 32'h0000_0001, 32'h8000_0005);
		add_item(5, 9, 32'hFFFF_FFFF, 32'h8000_0000);
		add_item(6, 10, 32'h0000_0001, 32'h0);
		add_item(6, 10, 32'h0000_0001, 32'h0);
		add_item(6, 10, 32'h0, 32'hFFFF_FFFF);
		random_items(150);
		drain();

		settings[0] = '0;
		settings[1] = '1;
		settings[2] = LR_W'($urandom_range(1, 16777214));
		settings[3] = LR_RESET;
		for (int ph = 0; ph < 4; ph++) begin
			write_rate(settings[ph]);
			gaps_on = (ph != 2);
			if (settings[ph] == '1) begin
				add_item(1, 20, 32'h8000_0000, 32'h7FFF_FFFF);
				add_item(2, 21, 32'h0000_0001, 32'h8000_0000);
				add_item(3, 22, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
			end
			random_items(120);
			drain();
		end

		$display("covered %0d items in %0d results, %0d with no step, %0d clamped",
			items_in, items_out, zero_steps, clamps);
		$display("rates 0, full scale, random and reset value; one long output hold-off");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/dapu_pkg.sv
rtl/core/dapu_ifs.sv
rtl/core/dapu_isqrt.sv
rtl/core/dapu_div.sv
rtl/core/delayed_adagrad_param_update.sv
rtl/core/dapu_checker.sv
sim/delayed_adagrad_param_update_test.sv
